[rtl/gdwm_pkg.sv]
// gdwm_pkg: shared constants, types and helpers for the gradient direction window matcher.
// Depends on nothing; imported by gradient_direction_window_match_core.
package gdwm_pkg;

    localparam int MASK_SIDE  = 9;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MASK_AREA  = MASK_SIDE * MASK_SIDE;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int CNT_W        = 16;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int IDX_W        = 7;
    localparam int GRAD_W       = 16;
    localparam int MIDX_W       = $clog2(MASK_AREA);
    localparam int SLOT_W       = $clog2(MASK_SIDE);

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int MSUM_W  = 8;
    localparam int SCORE_W = 2;
    localparam int RSUM_W  = $clog2(3 * MASK_SIDE + 1);
    localparam int SUM_W   = $clog2(3 * MASK_AREA + 1);
    localparam int TOT_W   = (SUM_W > MSUM_W) ? SUM_W : MSUM_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_MASK  = 1'b0,
        KIND_PIXEL = 1'b1
    } item_kind_t;

    // sign/order flags of one gradient pair
    typedef struct packed {
        logic xp;
        logic xn;
        logic yp;
        logic yn;
        logic gt;
        logic lt;
    } feat_t;

    localparam int FEAT_W = $bits(feat_t);
    localparam int LINE_W = MASK_SIDE * FEAT_W;

    function automatic feat_t feat_of(logic signed [GRAD_W-1:0] x,
                                      logic signed [GRAD_W-1:0] y);
        feat_t f;
        f.xp = !x[GRAD_W-1] && (x != '0);
        f.xn = x[GRAD_W-1];
        f.yp = !y[GRAD_W-1] && (y != '0);
        f.yn = y[GRAD_W-1];
        f.gt = x > y;
        f.lt = x < y;
        return f;
    endfunction

    function automatic logic [1:0] agree(feat_t p, feat_t m);
        logic ax, ay, ao;
        ax = (p.xp & m.xp) | (p.xn & m.xn);
        ay = (p.yp & m.yp) | (p.yn & m.yn);
        ao = (p.gt & m.gt) | (p.lt & m.lt);
        return {1'b0, ax} + {1'b0, ay} + {1'b0, ao};
    endfunction

endpackage

[rtl/gradient_direction_window_match_core.sv]
// A pixel's result reaches m_* via line buffer, adder tree and output register; mask loads
// give no result. Throughput: one item per cycle, set by the single line-buffer port pair.
// The pipeline only stalls when its last stage is full while the output register is held.
// Reset (aresetn low, synchronous): counters, window and pipeline clear, size registers go
// to 640 x 480. Mask and line buffer contents are undefined until written; no clearing pass.
module gradient_direction_window_match_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [6:0] mask_index, [22:7] grad_x, [38:23] grad_y, [39] zero
    input  logic [gdwm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] match_sum, [9:8] score, [15:10] zero
    output logic [gdwm_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] window_valid
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gdwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gdwm_pkg::*;

    // ---------------- configuration ----------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CNT_W-1:0]        eff_w, eff_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_REG_W'(640);
            height_reg <= HEIGHT_REG_W'(480);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the buffer limits
    always_comb begin
        if (width_reg == '0)
            eff_w = CNT_W'(1);
        else if (CNT_W'(width_reg) > CNT_W'(MAX_WIDTH))
            eff_w = CNT_W'(MAX_WIDTH);
        else
            eff_w = CNT_W'(width_reg);
        if (height_reg == '0)
            eff_h = CNT_W'(1);
        else if (CNT_W'(height_reg) > CNT_W'(MAX_HEIGHT))
            eff_h = CNT_W'(MAX_HEIGHT);
        else
            eff_h = CNT_W'(height_reg);
    end

    // ---------------- input decode ----------------
    logic [IDX_W-1:0]         in_idx;
    logic signed [GRAD_W-1:0] in_gx, in_gy;
    feat_t                    in_feat;
    logic                     adv, in_acc, pix_acc, mask_acc;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_gx   = s_tdata[IDX_W +: GRAD_W];
    assign in_gy   = s_tdata[IDX_W+GRAD_W +: GRAD_W];
    assign in_feat = feat_of(in_gx, in_gy);

    // pipeline valid flags and output register
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic m_tvalid_reg;

    // everything moves unless the last stage is blocked by a held result
    assign adv      = !(p4_valid_reg && m_tvalid_reg && !m_tready);
    assign s_tready = adv;
    assign in_acc   = s_tvalid && adv;
    assign pix_acc  = in_acc && (item_kind_t'(s_tuser) == KIND_PIXEL);
    assign mask_acc = in_acc && (item_kind_t'(s_tuser) == KIND_MASK);

    // ---------------- mask store ----------------
    feat_t mask_reg [MASK_AREA];

    always_ff @(posedge aclk) begin
        if (mask_acc && (in_idx < IDX_W'(MASK_AREA)))
            mask_reg[in_idx[MIDX_W-1:0]] <= in_feat;
    end

    // ---------------- raster counters ----------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] rmod_reg, rmod_next;
    logic [CNT_W-1:0]  c_t, r_t;
    logic              row_inc;
    logic              win_ok;

    assign win_ok = (col_reg >= COL_W'(MASK_SIDE - 1)) && (row_reg >= ROW_W'(MASK_SIDE - 1));

    // rmod tracks the row modulo MASK_SIDE
    always_comb begin
        row_inc = 1'b0;
        c_t = CNT_W'(col_reg) + CNT_W'(1);
        r_t = CNT_W'(row_reg);
        if (c_t >= eff_w) begin
            c_t = '0;
            r_t = r_t + CNT_W'(1);
            row_inc = 1'b1;
            if (r_t >= eff_h)
                r_t = '0;
        end
        if (r_t >= eff_h)
            r_t = '0;
        col_next = c_t[COL_W-1:0];
        row_next = r_t[ROW_W-1:0];
        if (r_t == '0)
            rmod_next = '0;
        else if (row_inc)
            rmod_next = (rmod_reg == SLOT_W'(MASK_SIDE - 1)) ? '0 : rmod_reg + SLOT_W'(1);
        else
            rmod_next = rmod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            rmod_reg <= '0;
        end else if (pix_acc) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rmod_reg <= rmod_next;
        end
    end

    // ---------------- stage 1: line buffer read-modify-write ----------------
    // Each line word holds one column, one slot per row modulo MASK_SIDE.
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] line_q_reg, fwd_data_reg, old_word, new_word;
    logic              fwd_reg, line_we;
    feat_t             p1_feat_reg;
    logic [COL_W-1:0]  p1_col_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic              p1_ok_reg;
    feat_t             col_f [MASK_SIDE];

    assign line_we = adv && p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (line_we)
            line_mem[p1_col_reg] <= new_word;
        if (pix_acc) begin
            line_q_reg   <= line_mem[col_reg];
            // same-column write in the read cycle: take the new word
            fwd_reg      <= line_we && (p1_col_reg == col_reg);
            fwd_data_reg <= new_word;
            p1_feat_reg  <= in_feat;
            p1_col_reg   <= col_reg;
            p1_slot_reg  <= rmod_reg;
            p1_ok_reg    <= win_ok;
        end
    end

    assign old_word = fwd_reg ? fwd_data_reg : line_q_reg;

    // current pixel lands in its row slot; window row i reads slot (row + 1 + i) mod side
    always_comb begin
        logic [SLOT_W:0] sel;
        new_word = old_word;
        for (int s = 0; s < MASK_SIDE; s++)
            if (p1_slot_reg == SLOT_W'(s))
                new_word[s*FEAT_W +: FEAT_W] = p1_feat_reg;
        for (int i = 0; i < MASK_SIDE; i++) begin
            sel = {1'b0, p1_slot_reg} + (SLOT_W+1)'(i + 1);
            if (sel >= (SLOT_W+1)'(MASK_SIDE))
                sel = sel - (SLOT_W+1)'(MASK_SIDE);
            col_f[i] = '0;
            for (int s = 0; s < MASK_SIDE; s++)
                if (sel == (SLOT_W+1)'(s))
                    col_f[i] = new_word[s*FEAT_W +: FEAT_W];
        end
    end

    // window: newest column at the high index
    feat_t      win_reg  [MASK_SIDE][MASK_SIDE];
    feat_t      win_next [MASK_SIDE][MASK_SIDE];
    logic [1:0] agr_next [MASK_SIDE][MASK_SIDE];

    always_comb begin
        for (int i = 0; i < MASK_SIDE; i++) begin
            for (int j = 0; j < MASK_SIDE - 1; j++)
                win_next[i][j] = win_reg[i][j+1];
            win_next[i][MASK_SIDE-1] = col_f[i];
        end
        for (int i = 0; i < MASK_SIDE; i++)
            for (int j = 0; j < MASK_SIDE; j++)
                agr_next[i][j] = agree(win_next[i][j], mask_reg[i*MASK_SIDE+j]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MASK_SIDE; i++)
                for (int j = 0; j < MASK_SIDE; j++)
                    win_reg[i][j] <= '0;
        end else if (line_we) begin
            win_reg <= win_next;
        end
    end

    // ---------------- stages 2 to 4: adder tree ----------------
    logic [1:0]        agr_reg [MASK_SIDE][MASK_SIDE];
    logic [RSUM_W-1:0] rsum_reg [MASK_SIDE];
    logic [RSUM_W-1:0] rsum_next [MASK_SIDE];
    logic [SUM_W-1:0]  total_reg, total_next;
    logic              p2_ok_reg, p3_ok_reg, p4_ok_reg;

    always_comb begin
        for (int i = 0; i < MASK_SIDE; i++) begin
            rsum_next[i] = '0;
            for (int j = 0; j < MASK_SIDE; j++)
                rsum_next[i] = rsum_next[i] + RSUM_W'(agr_reg[i][j]);
        end
        total_next = '0;
        for (int i = 0; i < MASK_SIDE; i++)
            total_next = total_next + SUM_W'(rsum_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            agr_reg   <= agr_next;
            p2_ok_reg <= p1_ok_reg;
            rsum_reg  <= rsum_next;
            p3_ok_reg <= p2_ok_reg;
            total_reg <= total_next;
            p4_ok_reg <= p3_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= pix_acc;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    // ---------------- output register ----------------
    logic [TOT_W-1:0]   tot_ext;
    logic [MSUM_W-1:0]  msum_next;
    logic [SCORE_W-1:0] score_next;
    logic [MSUM_W-1:0]  msum_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               ok_reg;

    // score from the unsaturated sum, sum clipped to eight bits
    always_comb begin
        tot_ext = TOT_W'(total_reg);
        if (!p4_ok_reg)
            msum_next = '0;
        else if (tot_ext > TOT_W'(255))
            msum_next = MSUM_W'(255);
        else
            msum_next = tot_ext[MSUM_W-1:0];
        if (!p4_ok_reg)
            score_next = '0;
        else if (tot_ext >= TOT_W'(3 * MASK_AREA))
            score_next = SCORE_W'(3);
        else if (tot_ext >= TOT_W'(2 * MASK_AREA))
            score_next = SCORE_W'(2);
        else if (tot_ext >= TOT_W'(MASK_AREA))
            score_next = SCORE_W'(1);
        else
            score_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (adv && p4_valid_reg)
                m_tvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p4_valid_reg) begin
            msum_reg  <= msum_next;
            score_reg <= score_next;
            ok_reg    <= p4_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {(M_TDATA_W - MSUM_W - SCORE_W)'(0), score_reg, msum_reg};

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0))
        else $error("invalid window carries a nonzero result");

    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && p4_valid_reg |=> m_tvalid)
        else $error("last stage transfer did not reach the output");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && p4_valid_reg))
        else $error("input stalled without a held result");

endmodule
